>>> rtl/rdf_pkg.sv
package rdf_pkg;

  // Fixed sizes of the conversion.
  localparam int MAX_BASE    = 16;
  localparam int MIN_BASE    = 2;
  localparam int MAX_DIGITS  = 32;
  localparam int VALUE_W     = 32;
  localparam int SYM_W       = 8;
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);

  // Divider: quotient bits retired per cycle and cycles per digit.
  localparam int STEP_BITS   = 8;
  localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Symbol bytes that may not serve as digits.
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_WS_LO = 8'd9;
  localparam logic [SYM_W-1:0] SYM_WS_HI = 8'd13;

  // Register reset values: radix ten with symbols "0123456789".
  localparam logic [BASE_W-1:0]     BASE_SIZE_RST    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'd14648;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SIZE    = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input value
    logic div_step;   // run one divider cycle
    logic div_last;   // this divider cycle completes a digit
    logic prime;      // first digit read, sign symbol if negative
    logic emit_bad;   // emit the invalid-base result
    logic emit_digit; // emit the digit read last cycle
  } rdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic base_ok;    // configured base is usable
    logic conv_done;  // current digit is the final one
    logic rd_last;    // digit on the read port is the least significant
  } rdf_stat_t;

endpackage

>>> rtl/radix_digit_formatter.sv
// Integer-to-text converter with a configurable radix.
// Input: pulse start with in_value while busy is low; the value is transferred
// at that edge and busy rises on the next cycle until the item is finished.
// Output: each symbol is on out_symbol for one cycle with out_strobe high;
// out_last marks the final symbol of the item. A negative value gives a
// leading '-' and then its magnitude. The receiver cannot stall the output.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 radix,
// 1 symbols 0..7, 2 symbols 8..15) at the clock edge; write only while idle.
// An unusable radix or symbol set gives one strobe with out_bad_base and
// out_last high and a zero symbol, from the result register after the check.
// Sequence for a value: a base check, then the shared divider for each digit
// (eight quotient bits a cycle), a read of the first stored digit, then one
// symbol per cycle. The '-' of a negative value comes with that read and
// precedes the first digit; no new item is taken before the last symbol.
// Synchronous reset restores radix ten with symbols 0 to 9 and aborts any item.
module radix_digit_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rdf_pkg::VALUE_W-1:0]  in_value,
  input  logic                                cfg_we,
  input  logic [rdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_strobe,
  output logic [rdf_pkg::SYM_W-1:0]           out_symbol,
  output logic                                out_last,
  output logic                                out_bad_base
);
  import rdf_pkg::*;

  rdf_cmd_t  cmd;
  rdf_stat_t stat;
  logic      busy_int;

  // Sequencer.
  rdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && !busy_int),
    .busy  (busy_int),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Divider, digit store and result register.
  rdf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_strobe   (out_strobe),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .out_bad_base (out_bad_base)
  );

  assign busy = busy_int;

endmodule

>>> rtl/rdf_ctrl.sv
module rdf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output rdf_pkg::rdf_cmd_t cmd,
  input  rdf_pkg::rdf_stat_t stat
);
  import rdf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PRIME,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt = '0;
        if (stat.base_ok) begin
          state_nxt = S_DIV;
        end else begin
          cmd.emit_bad = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          if (stat.conv_done) begin
            state_nxt = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, step counter and registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  // At most one kind of result is produced in a cycle.
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_bad, cmd.prime, cmd.emit_digit}))
    else $error("controller issues two result commands at once");

  // An invalid-base result ends the item.
  a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_bad |=> !busy)
    else $error("controller stays busy after an invalid-base result");

endmodule

>>> rtl/rdf_dp.sv
module rdf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [rdf_pkg::VALUE_W-1:0]  in_value,
  input  logic                                cfg_we,
  input  logic [rdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  rdf_pkg::rdf_cmd_t                   cmd,
  output rdf_pkg::rdf_stat_t                  stat,
  output logic                                out_strobe,
  output logic [rdf_pkg::SYM_W-1:0]           out_symbol,
  output logic                                out_last,
  output logic                                out_bad_base
);
  import rdf_pkg::*;

  logic [BASE_W-1:0]     base_r;
  logic [CFG_DATA_W-1:0] sym_lo_r;
  logic [CFG_DATA_W-1:0] sym_hi_r;
  logic [SYM_W-1:0]      sym_tab [MAX_BASE];
  logic                  base_ok;
  logic                  base_ok_r;

  logic                  neg_r;
  logic [VALUE_W-1:0]    quot_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [CNT_W-1:0]      count_r;
  logic [VALUE_W-1:0]    quot_nxt;
  logic [DIGIT_W-1:0]    rem_nxt;

  logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic [CNT_W-1:0]      count_dec;

  logic                  strobe_r;
  logic [SYM_W-1:0]      symbol_r;
  logic                  last_r;
  logic                  bad_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_SIZE_RST;
      sym_lo_r <= SYMBOLS_LOW_RST;
      sym_hi_r <= SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SIZE:    base_r   <= cfg_wdata[BASE_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r <= cfg_wdata;
        CFG_SYMBOLS_HIGH: sym_hi_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Symbol table, one byte per digit value.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym_tab[i]   = sym_lo_r[SYM_W*i +: SYM_W];
      sym_tab[i+8] = sym_hi_r[SYM_W*i +: SYM_W];
    end
  end

  // Base check: radix in range, no sign or blank symbols, no repeats among used symbols.
  always_comb begin
    base_ok = (base_r >= BASE_W'(MIN_BASE)) && (base_r <= BASE_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (BASE_W'(i) < base_r) begin
        if (sym_tab[i] == SYM_MINUS || sym_tab[i] == SYM_PLUS ||
            sym_tab[i] == SYM_SPACE ||
            (sym_tab[i] >= SYM_WS_LO && sym_tab[i] <= SYM_WS_HI)) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (BASE_W'(j) < base_r && sym_tab[j] == sym_tab[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base_ok_r <= base_ok;
  end

  // Divider cycle: restoring division by the radix, several quotient bits per cycle.
  always_comb begin
    logic [VALUE_W-1:0] sh;
    logic [DIGIT_W-1:0] r;
    logic [BASE_W-1:0]  part;
    sh = quot_r;
    r  = rem_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      part = {r, sh[VALUE_W-1]};
      sh   = {sh[VALUE_W-2:0], 1'b0};
      if (part >= base_r) begin
        part  = part - base_r;
        sh[0] = 1'b1;
      end
      r = part[DIGIT_W-1:0];
    end
    quot_nxt = sh;
    rem_nxt  = r;
  end

  assign count_dec = count_r - 1'b1;

  // Conversion state: magnitude, partial remainder and digit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r   <= 1'b0;
      quot_r  <= '0;
      rem_r   <= '0;
      count_r <= '0;
    end else if (cmd.load) begin
      neg_r   <= in_value[VALUE_W-1];
      quot_r  <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
      rem_r   <= '0;
      count_r <= '0;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      if (cmd.div_last) begin
        rem_r   <= '0;
        count_r <= count_r + 1'b1;
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (cmd.prime || (cmd.emit_digit && count_r != '0)) begin
      count_r <= count_dec;
    end
  end

  // Digit store, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      digit_mem[count_r[ADDR_W-1:0]] <= rem_nxt;
    end
    if (cmd.prime || (cmd.emit_digit && count_r != '0)) begin
      rd_data_r <= digit_mem[count_dec[ADDR_W-1:0]];
    end
  end

  // Result register: one transfer per strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      symbol_r <= '0;
      last_r   <= 1'b0;
      bad_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cmd.emit_bad) begin
        strobe_r <= 1'b1;
        symbol_r <= '0;
        last_r   <= 1'b1;
        bad_r    <= 1'b1;
      end else if (cmd.prime) begin
        strobe_r <= neg_r;
        symbol_r <= SYM_MINUS;
        last_r   <= 1'b0;
        bad_r    <= 1'b0;
      end else if (cmd.emit_digit) begin
        strobe_r <= 1'b1;
        symbol_r <= sym_tab[rd_data_r];
        last_r   <= (count_r == '0);
        bad_r    <= 1'b0;
      end
    end
  end

  assign stat.base_ok   = base_ok_r;
  assign stat.conv_done = (quot_nxt == '0) || (count_r == CNT_W'(MAX_DIGITS - 1));
  assign stat.rd_last   = (count_r == '0);

  assign out_strobe   = strobe_r;
  assign out_symbol   = symbol_r;
  assign out_last     = last_r;
  assign out_bad_base = bad_r;

  // An invalid-base result is a lone, zero symbol.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && bad_r) |-> (last_r && symbol_r == '0))
    else $error("invalid-base result is malformed");

  // The digit count never passes the store depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflows the store");

  // Reading starts only with at least one stored digit.
  a_prime_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prime |-> (count_r != '0))
    else $error("digit readout starts with an empty store");

endmodule
